// ===== rtl/pffa_pkg.sv =====
package pffa_pkg;

   // geometry
   localparam int PAGE_COUNT     = 4;
   localparam int PAGE_BYTES     = 4096;
   localparam int GRANULE_BYTES  = 256;   // power of two
   localparam int GRANS_PER_PAGE = PAGE_BYTES / GRANULE_BYTES;
   localparam int TOTAL_GRANS    = PAGE_COUNT * GRANS_PER_PAGE;
   localparam int GRAN_SHIFT     = $clog2(GRANULE_BYTES);

   // field widths
   localparam int FUNC_W   = 1;
   localparam int REQ_W    = 13;
   localparam int PAGE_W   = 2;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;

   // internal widths
   localparam int ADDR_W = $clog2(TOTAL_GRANS);
   localparam int G_W    = $clog2(GRANS_PER_PAGE + 1);
   localparam int LEN_W  = $clog2(GRANS_PER_PAGE + 1);

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [OFFSET_W-1:0] OFF_MASK = OFFSET_W'(GRANULE_BYTES - 1);

   typedef struct packed {
      logic             used;
      logic [LEN_W-1:0] length;
   } seg_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      seg_entry_type     wr_data;
   } mem_req_type;

   function automatic logic [ADDR_W-1:0] seg_addr(input logic [PAGE_W-1:0] page,
                                                  input logic [G_W-1:0] g);
      seg_addr = ADDR_W'(ADDR_W'(page) * ADDR_W'(GRANS_PER_PAGE) + ADDR_W'(g));
   endfunction

endpackage

// ===== rtl/pffa_if.sv =====
interface pffa_req_if;
   logic                           valid;
   logic                           ready;
   logic [pffa_pkg::FUNC_W-1:0]    func;
   logic [pffa_pkg::REQ_W-1:0]     request_bytes;
   logic [pffa_pkg::PAGE_W-1:0]    free_page;
   logic [pffa_pkg::OFFSET_W-1:0]  free_offset;

   modport source(output valid, func, request_bytes, free_page, free_offset,
                  input ready);
   modport sink(input valid, func, request_bytes, free_page, free_offset,
                output ready);
endinterface

interface pffa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pffa_pkg::STATUS_W-1:0]  status;
   logic [pffa_pkg::PAGE_W-1:0]    block_page;
   logic [pffa_pkg::OFFSET_W-1:0]  block_offset;

   modport source(output valid, status, block_page, block_offset, input ready);
   modport sink(input valid, status, block_page, block_offset, output ready);
endinterface

// ===== rtl/paged_first_fit_allocator.sv =====
// A bad size or bad free address goes straight to the result word; otherwise the sequencer
//   reads and evaluates segment entries in turn, does the allocate or free writes, then
//   loads the result word. One word at a time: the next word is taken only once the result
//   word has loaded; the walk over the segment memory sets the pace.
// A stalled result word holds the next result in the done state until the word leaves.
// Reset: synchronous; clears the per-entry valid bits so every page reads as one free segment.
module paged_first_fit_allocator (
   input  logic       clock,
   input  logic       reset,
   pffa_req_if.sink   req_chan,
   pffa_rsp_if.source rsp_chan
);
   import pffa_pkg::*;

   mem_req_type   mem_req;
   seg_entry_type rd_data;

   // sequencer: walks segments, carves on allocate, coalesces on free
   pffa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   // segment table: length and used flag per granule, registered read
   pffa_seg_mem u_seg_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ===== rtl/pffa_seg_mem.sv =====
module pffa_seg_mem (
   input  logic                    clock,
   input  logic                    reset,
   input  pffa_pkg::mem_req_type   mem_req,
   output pffa_pkg::seg_entry_type rd_data
);
   import pffa_pkg::*;

   seg_entry_type             mem [TOTAL_GRANS];
   logic [TOTAL_GRANS-1:0]    valid_ff;
   seg_entry_type             rd_data_ff;
   logic                      rd_valid_ff;
   logic [ADDR_W-1:0]         rd_addr_ff;
   seg_entry_type             reset_entry;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
         rd_addr_ff <= mem_req.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   // unwritten entry: a full free page at each page start, nothing elsewhere
   always_comb begin
      reset_entry.used   = 1'b0;
      reset_entry.length = ((rd_addr_ff % GRANS_PER_PAGE) == 0) ?
                           LEN_W'(GRANS_PER_PAGE) : '0;
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : reset_entry;

endmodule

// ===== rtl/pffa_ctrl.sv =====
module pffa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   pffa_req_if.sink                req_chan,
   pffa_rsp_if.source              rsp_chan,
   output pffa_pkg::mem_req_type   mem_req,
   input  pffa_pkg::seg_entry_type rd_data
);
   import pffa_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_READ     = 4'd1;
   localparam logic [3:0] S_EVAL     = 4'd2;
   localparam logic [3:0] S_AWR2     = 4'd3;
   localparam logic [3:0] S_READ_NXT = 4'd4;
   localparam logic [3:0] S_EVAL_NXT = 4'd5;
   localparam logic [3:0] S_FWR1     = 4'd6;
   localparam logic [3:0] S_FWR2     = 4'd7;
   localparam logic [3:0] S_FWR3     = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [REQ_W-1:0]    need_ff, need_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [G_W-1:0]      g_ff, g_in;
   logic [G_W-1:0]      target_ff, target_in;
   logic [G_W-1:0]      prev_g_ff, prev_g_in;
   logic [LEN_W-1:0]    prev_len_ff, prev_len_in;
   logic                prev_used_ff, prev_used_in;
   logic                have_prev_ff, have_prev_in;
   logic [LEN_W-1:0]    cur_len_ff, cur_len_in;
   logic                merge_ff, merge_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PAGE_W-1:0]   res_page_ff, res_page_in;
   logic [G_W-1:0]      res_g_ff, res_g_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [PAGE_W-1:0]   out_page_ff, out_page_in;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;

   logic [G_W:0]              g_sum;
   logic                      prev_merge;
   logic [OFFSET_W-1:0]       req_target;
   logic [OFFSET_W+G_W-1:0]   res_off_wide;

   assign g_sum        = (G_W + 1)'(g_ff) + (G_W + 1)'(rd_data.length);
   assign prev_merge   = have_prev_ff && !prev_used_ff;
   assign req_target   = req_chan.free_offset >> GRAN_SHIFT;
   assign res_off_wide = (OFFSET_W + G_W)'(res_g_ff) << GRAN_SHIFT;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      need_in       = need_ff;
      page_in       = page_ff;
      g_in          = g_ff;
      target_in     = target_ff;
      prev_g_in     = prev_g_ff;
      prev_len_in   = prev_len_ff;
      prev_used_in  = prev_used_ff;
      have_prev_in  = have_prev_ff;
      cur_len_in    = cur_len_ff;
      merge_in      = merge_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_g_in      = res_g_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_page_in   = out_page_ff;
      out_offset_in = out_offset_ff;
      mem_req       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               func_in      = req_chan.func;
               need_in      = req_chan.request_bytes >> GRAN_SHIFT;
               g_in         = '0;
               have_prev_in = 1'b0;
               target_in    = G_W'(req_target);
               res_page_in  = '0;
               res_g_in     = '0;
               if (req_chan.func == FUNC_ALLOC) begin
                  page_in = '0;
                  if (req_chan.request_bytes == '0 ||
                      (req_chan.request_bytes & REQ_W'(GRANULE_BYTES - 1)) != '0) begin
                     res_status_in = ST_BAD_SIZE;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  page_in = req_chan.free_page;
                  if (int'(req_chan.free_page) >= PAGE_COUNT ||
                      (req_chan.free_offset & OFF_MASK) != '0 ||
                      int'(req_target) >= GRANS_PER_PAGE) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end

         S_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = seg_addr(page_ff, g_ff);
            state_in        = S_EVAL;
         end

         S_EVAL: begin
            if (func_ff == FUNC_ALLOC) begin
               if (rd_data.length != '0 && !rd_data.used &&
                   REQ_W'(rd_data.length) >= need_ff) begin
                  // first fit
                  if (REQ_W'(rd_data.length) > need_ff) begin
                     // keep the bottom free, hand out the top
                     mem_req.wr_en          = 1'b1;
                     mem_req.wr_addr        = seg_addr(page_ff, g_ff);
                     mem_req.wr_data.used   = 1'b0;
                     mem_req.wr_data.length = rd_data.length - LEN_W'(need_ff);
                     g_in     = G_W'(g_ff + G_W'(rd_data.length - LEN_W'(need_ff)));
                     state_in = S_AWR2;
                  end else begin
                     mem_req.wr_en          = 1'b1;
                     mem_req.wr_addr        = seg_addr(page_ff, g_ff);
                     mem_req.wr_data.used   = 1'b1;
                     mem_req.wr_data.length = rd_data.length;
                     res_status_in = ST_OK;
                     res_page_in   = page_ff;
                     res_g_in      = g_ff;
                     state_in      = S_DONE;
                  end
               end else if (rd_data.length != '0 && int'(g_sum) < GRANS_PER_PAGE) begin
                  g_in     = G_W'(g_sum);
                  state_in = S_READ;
               end else if (int'(page_ff) == PAGE_COUNT - 1) begin
                  res_status_in = ST_NO_SPACE;
                  res_page_in   = '0;
                  res_g_in      = '0;
                  state_in      = S_DONE;
               end else begin
                  page_in  = page_ff + 1'b1;
                  g_in     = '0;
                  state_in = S_READ;
               end
            end else begin
               if (rd_data.length == '0 || g_ff > target_ff) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else if (g_ff == target_ff) begin
                  if (!rd_data.used) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     cur_len_in = rd_data.length;
                     merge_in   = 1'b0;
                     if (int'(g_sum) < GRANS_PER_PAGE) begin
                        g_in     = G_W'(g_sum);
                        state_in = S_READ_NXT;
                     end else begin
                        state_in = S_FWR1;
                     end
                  end
               end else begin
                  prev_g_in    = g_ff;
                  prev_len_in  = rd_data.length;
                  prev_used_in = rd_data.used;
                  have_prev_in = 1'b1;
                  if (int'(g_sum) >= GRANS_PER_PAGE) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     g_in     = G_W'(g_sum);
                     state_in = S_READ;
                  end
               end
            end
         end

         S_AWR2: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = seg_addr(page_ff, g_ff);
            mem_req.wr_data.used   = 1'b1;
            mem_req.wr_data.length = LEN_W'(need_ff);
            res_status_in = ST_OK;
            res_page_in   = page_ff;
            res_g_in      = g_ff;
            state_in      = S_DONE;
         end

         S_READ_NXT: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = seg_addr(page_ff, g_ff);
            state_in        = S_EVAL_NXT;
         end

         S_EVAL_NXT: begin
            merge_in = !rd_data.used && rd_data.length != '0;
            if (!rd_data.used && rd_data.length != '0) begin
               cur_len_in = LEN_W'(cur_len_ff + rd_data.length);
            end
            state_in = S_FWR1;
         end

         S_FWR1: begin
            // freed segment, possibly grown by the free segment above; zero length if folded below
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = seg_addr(page_ff, target_ff);
            mem_req.wr_data.used   = 1'b0;
            mem_req.wr_data.length = prev_merge ? '0 : cur_len_ff;
            res_status_in = ST_OK;
            res_page_in   = page_ff;
            res_g_in      = target_ff;
            if (merge_ff) begin
               state_in = S_FWR2;
            end else if (prev_merge) begin
               state_in = S_FWR3;
            end else begin
               state_in = S_DONE;
            end
         end

         S_FWR2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = seg_addr(page_ff, g_ff);
            state_in        = prev_merge ? S_FWR3 : S_DONE;
         end

         S_FWR3: begin
            // fold into the free segment below
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = seg_addr(page_ff, prev_g_ff);
            mem_req.wr_data.used   = 1'b0;
            mem_req.wr_data.length = LEN_W'(prev_len_ff + cur_len_ff);
            state_in               = S_DONE;
         end

         S_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_page_in   = res_page_ff;
               out_offset_in = res_off_wide[OFFSET_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      need_ff       <= need_in;
      page_ff       <= page_in;
      g_ff          <= g_in;
      target_ff     <= target_in;
      prev_g_ff     <= prev_g_in;
      prev_len_ff   <= prev_len_in;
      prev_used_ff  <= prev_used_in;
      have_prev_ff  <= have_prev_in;
      cur_len_ff    <= cur_len_in;
      merge_ff      <= merge_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_g_ff      <= res_g_in;
      out_status_ff <= out_status_in;
      out_page_ff   <= out_page_in;
      out_offset_ff <= out_offset_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.block_page   = out_page_ff;
   assign rsp_chan.block_offset = out_offset_ff;

endmodule

// ===== rtl/pffa_checker.sv =====
module pffa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pffa_pkg::STATUS_W-1:0] rsp_status,
   input logic [pffa_pkg::PAGE_W-1:0]   rsp_block_page,
   input logic [pffa_pkg::OFFSET_W-1:0] rsp_block_offset
);
   import pffa_pkg::*;

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // one request in flight: accepting a word drops ready
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // a failed request reports no block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_block_page == '0 && rsp_block_offset == '0))
      else $error("failure with nonzero block");

   // a granted block starts on a granule boundary
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> ((rsp_block_offset & OFF_MASK) == '0))
      else $error("block offset not granule aligned");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_block_page) &&
          $stable(rsp_block_offset)))
      else $error("stalled result word changed");

endmodule

bind paged_first_fit_allocator pffa_checker u_pffa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_block_page   (rsp_chan.block_page),
   .rsp_block_offset (rsp_chan.block_offset)
);

// ===== test/paged_first_fit_allocator_tb.sv =====
module paged_first_fit_allocator_tb;
   import pffa_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_WORDS = 550;
   // worst allocate walks every segment entry; drain a while past that
   localparam int TAIL_CYCLES  = 150;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [REQ_W-1:0]    req_bytes;
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
   } request_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
   } reply_word_type;

   logic clock = 1'b0;
   logic reset;

   pffa_req_if req_bus();
   pffa_rsp_if rsp_bus();

   paged_first_fit_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the segment map. span_len[g] is the length in granules of the
   // segment starting at granule g (0 if none starts there); span_used[g]
   // marks it allocated. One spare entry past the end.
   // ---------------------------------------------------------------------
   int unsigned span_len [0:TOTAL_GRANS];
   bit          span_used[0:TOTAL_GRANS];

   request_word_type pending_words[$];     // words waiting for the driver
   reply_word_type   predicted_replies[$]; // one per accepted request word
   logic [PAGE_W+OFFSET_W-1:0] live_blocks[$];  // {page, offset} now allocated
   logic [PAGE_W+OFFSET_W-1:0] freed_blocks[$]; // recently released, for double frees

   int  fail_count = 0;
   int  cycle_count = 0;
   bit  steady_run = 1'b0;  // when set, neither side idles
   int  send_gap;
   int  recv_stall;
   bit  took;
   reply_word_type want;

   // Most gaps short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // First fit over pages in order, free segments in address order; a larger
   // segment gives the block from its top end.
   function automatic reply_word_type carve_block(input logic [REQ_W-1:0] req_bytes);
      reply_word_type r;
      int unsigned need, base, g, len, top, p;
      r = '{ST_NO_SPACE, '0, '0};
      if (req_bytes == 0 || (req_bytes % GRANULE_BYTES) != 0) begin
         r.status = ST_BAD_SIZE;
         return r;
      end
      need = req_bytes / GRANULE_BYTES;
      for (p = 0; p < PAGE_COUNT; p++) begin
         base = p * GRANS_PER_PAGE;
         g = 0;
         while (g < GRANS_PER_PAGE) begin
            len = span_len[base + g];
            if (len == 0) break;
            if (!span_used[base + g] && len >= need) begin
               if (len > need) begin
                  span_len[base + g] = len - need;
                  top = g + (len - need);
                  span_len[base + top]  = need;
                  span_used[base + top] = 1'b1;
               end else begin
                  top = g;
                  span_used[base + g] = 1'b1;
               end
               r.status = ST_OK;
               r.page   = PAGE_W'(p);
               r.offset = OFFSET_W'(top * GRANULE_BYTES);
               return r;
            end
            g += len;
         end
      end
      return r;
   endfunction

   // Release a used segment by its start, merging with free neighbors.
   function automatic reply_word_type release_block(input logic [PAGE_W-1:0] page,
                                                    input logic [OFFSET_W-1:0] offset);
      reply_word_type r;
      int unsigned base, g, target, len, nxt, prev;
      bit have_prev;
      r = '{ST_NOT_FOUND, '0, '0};
      if (page >= PAGE_COUNT || (offset % GRANULE_BYTES) != 0) return r;
      target = offset / GRANULE_BYTES;
      if (target >= GRANS_PER_PAGE) return r;
      base = page * GRANS_PER_PAGE;
      g = 0;
      prev = 0;
      have_prev = 1'b0;
      while (g < GRANS_PER_PAGE) begin
         len = span_len[base + g];
         if (len == 0 || g > target) break;
         if (g == target) begin
            if (!span_used[base + g]) break;   // already free: double free
            span_used[base + g] = 1'b0;
            nxt = g + len;
            if (nxt < GRANS_PER_PAGE && !span_used[base + nxt]
                && span_len[base + nxt] != 0) begin
               span_len[base + g]   = len + span_len[base + nxt];
               span_len[base + nxt] = 0;
            end
            if (have_prev && !span_used[base + prev]) begin
               span_len[base + prev] += span_len[base + g];
               span_len[base + g] = 0;
            end
            r.status = ST_OK;
            r.page   = page;
            r.offset = OFFSET_W'(target * GRANULE_BYTES);
            return r;
         end
         prev = g;
         have_prev = 1'b1;
         g += len;
      end
      return r;
   endfunction

   // Expected reply for an accepted word; also keeps the live block list that
   // steers the random frees.
   function automatic reply_word_type predict_reply(input request_word_type w);
      reply_word_type r;
      int i;
      if (w.func == FUNC_ALLOC) begin
         r = carve_block(w.req_bytes);
         if (r.status == ST_OK) live_blocks.push_back({r.page, r.offset});
      end else begin
         r = release_block(w.page, w.offset);
         if (r.status == ST_OK) begin
            for (i = 0; i < live_blocks.size(); i++) begin
               if (live_blocks[i] == {r.page, r.offset}) begin
                  live_blocks.delete(i);
                  break;
               end
            end
            freed_blocks.push_back({r.page, r.offset});
            if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents the head of pending_words, holds it until ready, then
   // idles for a random gap. Prediction happens at the accepting edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         took = req_bus.valid && req_bus.ready;
         if (took) begin
            predicted_replies.push_back(predict_reply(pending_words.pop_front()));
            send_gap = pick_gap();
         end
         // a word not yet taken stays on the bus untouched
         if (!req_bus.valid || took) begin
            if (send_gap > 0) begin
               req_bus.valid <= 1'b0;
               send_gap--;
            end else if (pending_words.size() != 0) begin
               req_bus.valid         <= 1'b1;
               req_bus.func          <= pending_words[0].func;
               req_bus.request_bytes <= pending_words[0].req_bytes;
               req_bus.free_page     <= pending_words[0].page;
               req_bus.free_offset   <= pending_words[0].offset;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted reply against the oldest prediction and
   // throttles ready, sometimes while a reply is already waiting.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t: unexpected reply status %0d page %0d offset %0d", $time,
                        rsp_bus.status, rsp_bus.block_page, rsp_bus.block_offset);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.block_page !== want.page
                   || rsp_bus.block_offset !== want.offset) begin
                  $display({"%0t: reply mismatch, expected status %0d page %0d offset %0d,",
                            " got status %0d page %0d offset %0d"},
                           $time, want.status, want.page, want.offset,
                           rsp_bus.status, rsp_bus.block_page, rsp_bus.block_offset);
                  fail_count++;
               end
            end
            recv_stall = pick_gap();
         end else if (rsp_bus.ready && $urandom_range(0, 9) == 0) begin
            recv_stall = pick_gap();
         end
         if (recv_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Wait until the driver has room; the previous word is then already
   // predicted, so live_blocks is current.
   task automatic await_slot();
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   task automatic send(input logic [FUNC_W-1:0] func, input int req_bytes,
                       input int page, input int offset);
      request_word_type w;
      await_slot();
      w.func      = func;
      w.req_bytes = REQ_W'(req_bytes);
      w.page      = PAGE_W'(page);
      w.offset    = OFFSET_W'(offset);
      pending_words.push_back(w);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || predicted_replies.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int i, n, pick, free_bias;
      logic [PAGE_W+OFFSET_W-1:0] key;
      request_word_type w;

      for (i = 0; i <= TOTAL_GRANS; i++) begin
         span_len[i]  = 0;
         span_used[i] = 1'b0;
      end
      for (i = 0; i < PAGE_COUNT; i++) span_len[i * GRANS_PER_PAGE] = GRANS_PER_PAGE;

      reset = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_ALLOC;
      req_bus.request_bytes = '0;
      req_bus.free_page     = '0;
      req_bus.free_offset   = '0;
      rsp_bus.ready         = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: bad sizes, oversize, carving from the top, bad frees,
      // merge on both sides, double free, exact fit of whole pages
      send(FUNC_ALLOC, 0, 3, 4095);      // zero size
      send(FUNC_ALLOC, 100, 0, 0);       // not a granule multiple
      send(FUNC_ALLOC, 8191, 2, 1);      // largest field value, odd
      send(FUNC_ALLOC, 4352, 0, 0);      // one granule more than a page
      send(FUNC_ALLOC, 7936, 1, 0);      // far beyond a page
      send(FUNC_ALLOC, 256, 0, 0);       // page 0 top granule
      send(FUNC_ALLOC, 512, 0, 0);       // just below it
      send(FUNC_FREE, 8191, 0, 3841);    // unaligned
      send(FUNC_FREE, 0, 0, 0);          // start of a free segment
      send(FUNC_FREE, 0, 0, 3584);       // inside a used segment
      send(FUNC_FREE, 0, 0, 3840);       // ok, no free neighbor above
      send(FUNC_FREE, 0, 0, 3328);       // ok, merges both sides
      send(FUNC_FREE, 0, 0, 3328);       // double free
      for (i = 0; i < PAGE_COUNT; i++) send(FUNC_ALLOC, PAGE_BYTES, 0, 0);
      send(FUNC_ALLOC, 256, 0, 0);       // everything taken
      send(FUNC_FREE, 0, 3, 0);
      send(FUNC_FREE, 0, 1, 4095);       // last byte of a page
      send(FUNC_FREE, 0, 3, 0);          // double free
      send(FUNC_ALLOC, PAGE_BYTES, 3, 4095);
      send(FUNC_FREE, 0, 2, 0);
      send(FUNC_FREE, 0, 1, 0);

      // random: mostly well-formed allocate/free traffic, some noise
      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 100) steady_run = 1'b1;
         if (i == 160) steady_run = 1'b0;
         if (i == RANDOM_WORDS / 2) drain();   // sender holds off until all replies are in

         await_slot();
         w.func      = FUNC_ALLOC;
         w.req_bytes = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
         w.page      = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
         w.offset    = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
         pick = $urandom_range(0, 99);
         free_bias = (live_blocks.size() > 24) ? 65 : 40;

         if (pick < 85) begin
            if (live_blocks.size() != 0 && $urandom_range(0, 99) < free_bias) begin
               key = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
               w.func   = FUNC_FREE;
               w.page   = key[PAGE_W+OFFSET_W-1:OFFSET_W];
               w.offset = key[OFFSET_W-1:0];
            end else begin
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, GRANS_PER_PAGE)
                                               : $urandom_range(1, 4);
               w.req_bytes = REQ_W'(n * GRANULE_BYTES);
            end
         end else if (pick < 89) begin
            // random size, usually malformed; already in w.req_bytes
         end else if (pick < 92) begin
            w.req_bytes = REQ_W'($urandom_range(GRANS_PER_PAGE + 1, 31) * GRANULE_BYTES);
         end else if (pick < 95) begin
            w.func   = FUNC_FREE;
            w.offset = OFFSET_W'($urandom_range(0, GRANS_PER_PAGE - 1) * GRANULE_BYTES);
         end else if (pick < 97) begin
            w.func = FUNC_FREE;  // arbitrary offset, mostly unaligned
         end else begin
            w.func = FUNC_FREE;
            if (freed_blocks.size() != 0) begin
               key = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
               w.page   = key[PAGE_W+OFFSET_W-1:OFFSET_W];
               w.offset = key[OFFSET_W-1:0];
            end
         end
         pending_words.push_back(w);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pffa_pkg.sv
rtl/pffa_if.sv
rtl/pffa_seg_mem.sv
rtl/pffa_ctrl.sv
rtl/paged_first_fit_allocator.sv
rtl/pffa_checker.sv
test/paged_first_fit_allocator_tb.sv
